[design/bhl_pkg.sv]
package bhl_pkg;

  // Field widths of the word on each channel.
  localparam int KIND_W   = 2;
  localparam int HANDLE_W = 32;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  // Operation codes carried on the kind field.
  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 2'd0,
    KIND_PUSH_BACK  = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_GET        = 2'd3
  } kind_e;

  // Status codes reported with each result.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERWRITE = 2'd1,
    STATUS_DROPPED   = 2'd2,
    STATUS_EMPTY     = 2'd3
  } status_e;

  // Result information that the controller settles when a word is accepted.
  typedef struct packed {
    logic                 hit;
    logic [COUNT_W-1:0]   count;
    status_e              status;
  } res_info_t;

endpackage

[design/bhl_ram.sv]
module bhl_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // One read port with registered data; the data holds between reads.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

[design/bhl_ctrl.sv]
module bhl_ctrl #(
  parameter int CAPACITY = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  bhl_pkg::kind_e                kind_i,
  input  logic [bhl_pkg::POS_W-1:0]     position_i,
  output logic                          wr_en_o,
  output logic [$clog2(CAPACITY)-1:0]   wr_addr_o,
  output logic                          rd_en_o,
  output logic [$clog2(CAPACITY)-1:0]   rd_addr_o,
  output bhl_pkg::res_info_t            info_o
);

  import bhl_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int OW = (CW > POS_W) ? CW : POS_W;
  localparam int SW = OW + 1;

  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          full;
  logic          empty;
  logic [AW-1:0] head_inc;
  logic [AW-1:0] head_dec;
  logic [AW-1:0] tail_addr;
  logic [AW-1:0] get_addr;
  logic          get_hit;

  // Ring offset from the head, wrapped once since the sum stays below twice the depth.
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [OW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(CAPACITY)) begin
      sum = sum - SW'(CAPACITY);
    end
    return AW'(sum);
  endfunction

  // Pointer arithmetic on the ring.
  assign full      = (cnt_q == CW'(CAPACITY));
  assign empty     = (cnt_q == '0);
  assign head_inc  = (head_q == AW'(CAPACITY - 1)) ? '0 : head_q + 1'b1;
  assign head_dec  = (head_q == '0) ? AW'(CAPACITY - 1) : head_q - 1'b1;
  assign tail_addr = ring_add(head_q, OW'(cnt_q));
  assign get_addr  = ring_add(head_q, OW'(position_i));
  assign get_hit   = (OW'(position_i) < OW'(cnt_q));

  // Decode the accepted word into memory accesses and the next pointers.
  always_comb begin
    head_d        = head_q;
    cnt_d         = cnt_q;
    wr_en_o       = 1'b0;
    wr_addr_o     = head_q;
    rd_en_o       = 1'b0;
    rd_addr_o     = head_q;
    info_o.hit    = 1'b0;
    info_o.status = STATUS_OK;
    if (accept_i) begin
      unique case (kind_i)
        KIND_PUSH_FRONT: begin
          wr_en_o = 1'b1;
          if (full) begin
            // The head slot is overwritten and the count stays.
            info_o.status = STATUS_OVERWRITE;
          end else begin
            head_d    = head_dec;
            wr_addr_o = head_dec;
            cnt_d     = cnt_q + 1'b1;
          end
        end
        KIND_PUSH_BACK: begin
          if (full) begin
            info_o.status = STATUS_DROPPED;
          end else begin
            wr_en_o   = 1'b1;
            wr_addr_o = tail_addr;
            cnt_d     = cnt_q + 1'b1;
          end
        end
        KIND_POP_FRONT: begin
          if (empty) begin
            info_o.status = STATUS_EMPTY;
          end else begin
            rd_en_o    = 1'b1;
            info_o.hit = 1'b1;
            head_d     = head_inc;
            cnt_d      = cnt_q - 1'b1;
          end
        end
        KIND_GET: begin
          if (get_hit) begin
            rd_en_o    = 1'b1;
            rd_addr_o  = get_addr;
            info_o.hit = 1'b1;
          end
        end
        default: begin
          info_o.status = STATUS_OK;
        end
      endcase
    end
    info_o.count = COUNT_W'(cnt_d);
  end

  // Head pointer and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      cnt_q  <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CW'(CAPACITY))
    else $error("fill count exceeds capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni) head_q <= AW'(CAPACITY - 1))
    else $error("head pointer outside the ring");

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(wr_en_o && rd_en_o))
    else $error("read and write issued for the same word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && kind_i == KIND_GET) |=> (cnt_q == $past(cnt_q) && head_q == $past(head_q)))
    else $error("get changed the list state");

endmodule

[design/bounded_handle_list_top.sv]
// Bounded handle list: a packed list of up to CAPACITY handles kept as a ring in one
// synchronous memory, addressed by a head pointer and a fill count. Push front, push
// back, pop front and get by index each take one input word and return one result
// word carrying the value, its valid flag, the count after the operation and a
// status. A new word is accepted every cycle unless the input is stalled; each result
// passes through the registered memory read, held in the read stage, and then the
// output register. Validity follows the count alone, so the memory needs no clearing
// after reset and reset takes effect at once.
module bounded_handle_list_top #(
  parameter int CAPACITY = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [bhl_pkg::KIND_W-1:0]     kind_i,
  input  logic [bhl_pkg::HANDLE_W-1:0]   handle_i,
  input  logic [bhl_pkg::POS_W-1:0]      position_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [bhl_pkg::HANDLE_W-1:0]   value_o,
  output logic                           valid_res_o,
  output logic [bhl_pkg::COUNT_W-1:0]    count_o,
  output logic [bhl_pkg::STATUS_W-1:0]   status_o
);

  import bhl_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  logic               accept;
  logic               out_adv;
  logic               s1_valid_q;
  res_info_t          s1_info_q;
  res_info_t          info;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [HANDLE_W-1:0] rd_data;
  logic               out_valid_q;
  logic [HANDLE_W-1:0] value_q;
  logic               valid_res_q;
  logic [COUNT_W-1:0] count_q;
  status_e            status_q;

  // Handshake: the output register frees when empty or taken, the read stage follows.
  assign out_adv    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_adv;
  assign accept     = in_valid_i && !in_stall_o;

  bhl_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .kind_i     (kind_e'(kind_i)),
    .position_i (position_i),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .info_o     (info)
  );

  bhl_ram #(
    .DEPTH(CAPACITY),
    .WIDTH(HANDLE_W)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (handle_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Read stage: holds the result information while the memory data arrives.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (out_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_info_q <= info;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && s1_valid_q) begin
      value_q     <= s1_info_q.hit ? rd_data : '0;
      valid_res_q <= s1_info_q.hit;
      count_q     <= s1_info_q.count;
      status_q    <= s1_info_q.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign valid_res_o = valid_res_q;
  assign count_o     = count_q;
  assign status_o    = status_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> s1_valid_q)
    else $error("input stalled with an empty read stage");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_adv) |=> out_valid_q)
    else $error("read stage word lost on its way to the output");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STATUS_EMPTY) |-> (!valid_res_o && value_o == '0))
    else $error("pop on empty returned a value");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == STATUS_OVERWRITE || status_o == STATUS_DROPPED))
      |-> !valid_res_o)
    else $error("push result flagged as valid");

endmodule

[tb/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bhl_pkg::*;

  localparam int DEPTH        = 16;
  localparam int CYCLE_LIMIT  = 60000;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_MAX   = 10;

  // One expected result word.
  typedef struct {
    logic [HANDLE_W-1:0] value;
    logic                hit;
    logic [COUNT_W-1:0]  count;
    status_e             status;
  } list_result_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [KIND_W-1:0]   kind_i      = '0;
  logic [HANDLE_W-1:0] handle_i    = '0;
  logic [POS_W-1:0]    position_i  = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [HANDLE_W-1:0] value_o;
  logic                valid_res_o;
  logic [COUNT_W-1:0]  count_o;
  logic [STATUS_W-1:0] status_o;

  // Shadow copy of the list contents and its fill level.
  logic [HANDLE_W-1:0] shadow_slots [DEPTH];
  int                  shadow_fill = 0;

  list_result_t pending_results [$];
  list_result_t want;
  int           mismatch_total = 0;
  int           cycle_count    = 0;
  bit           quiet          = 1'b0;

  bounded_handle_list_top #(
    .CAPACITY(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .handle_i   (handle_i),
    .position_i (position_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .value_o    (value_o),
    .valid_res_o(valid_res_o),
    .count_o    (count_o),
    .status_o   (status_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Apply one operation to the shadow list and return the result it must give.
  function automatic list_result_t next_list_result(input kind_e op,
                                                    input logic [HANDLE_W-1:0] h,
                                                    input logic [POS_W-1:0] pos);
    list_result_t r;
    r.value  = '0;
    r.hit    = 1'b0;
    r.status = STATUS_OK;
    case (op)
      KIND_PUSH_FRONT: begin
        if (shadow_fill < DEPTH) begin
          for (int i = shadow_fill; i > 0; i--) shadow_slots[i] = shadow_slots[i-1];
          shadow_fill++;
        end else begin
          r.status = STATUS_OVERWRITE;
        end
        shadow_slots[0] = h;
      end
      KIND_PUSH_BACK: begin
        if (shadow_fill < DEPTH) begin
          shadow_slots[shadow_fill] = h;
          shadow_fill++;
        end else begin
          r.status = STATUS_DROPPED;
        end
      end
      KIND_POP_FRONT: begin
        if (shadow_fill > 0) begin
          r.value = shadow_slots[0];
          r.hit   = 1'b1;
          for (int i = 0; i + 1 < shadow_fill; i++) shadow_slots[i] = shadow_slots[i+1];
          shadow_slots[shadow_fill-1] = '0;
          shadow_fill--;
        end else begin
          r.status = STATUS_EMPTY;
        end
      end
      default: begin
        if (int'(pos) < shadow_fill) begin
          r.value = shadow_slots[pos];
          r.hit   = 1'b1;
        end
      end
    endcase
    r.count = shadow_fill[COUNT_W-1:0];
    return r;
  endfunction

  // Present one word, hold it until it is taken, then record its expected result.
  // Called just after a falling edge; returns just after the falling edge that follows acceptance.
  task automatic issue_list_op(input kind_e op, input logic [HANDLE_W-1:0] h,
                               input logic [POS_W-1:0] pos);
    int gap;
    if (!quiet && $urandom_range(99) < 7) begin
      gap = $urandom_range(3, 1);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= op;
    handle_i   <= h;
    position_i <= pos;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(next_list_result(op, h, pos));
    @(negedge clk_i);
  endtask

  // Handles lean toward the extremes now and then; zero shows up rarely.
  function automatic logic [HANDLE_W-1:0] pick_handle();
    int roll;
    roll = $urandom_range(99);
    if (roll < 3) return 32'h0000_0001;
    if (roll < 6) return 32'hFFFF_FFFF;
    if (roll < 7) return 32'h0000_0000;
    return $urandom();
  endfunction

  // Empty list: pop reports empty, reads at both ends miss.
  task automatic test_empty_list();
    issue_list_op(KIND_POP_FRONT, 32'h0, 4'd0);
    issue_list_op(KIND_GET, 32'h0, 4'd0);
    issue_list_op(KIND_GET, 32'h0, 4'd15);
  endtask

  // Fill to capacity from both ends, push into the full list from both ends, then read both ends.
  task automatic test_fill_to_capacity();
    logic [HANDLE_W-1:0] h;
    for (int k = 0; k < DEPTH; k++) begin
      case (k)
        0:       h = 32'h0000_0001;
        1:       h = 32'hFFFF_FFFF;
        2:       h = 32'h0000_0000;
        3:       h = 32'hAAAA_AAAA;
        4:       h = 32'h5555_5555;
        default: h = $urandom();
      endcase
      issue_list_op((k % 2 == 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT, h, 4'd0);
    end
    issue_list_op(KIND_PUSH_BACK, 32'h1234_5678, 4'd0);
    issue_list_op(KIND_PUSH_FRONT, 32'hFFFF_FFFE, 4'd0);
    issue_list_op(KIND_GET, 32'h0, 4'd0);
    issue_list_op(KIND_GET, 32'h0, 4'd15);
  endtask

  // One pop from the full list frees the last slot, so a get there must then miss.
  task automatic test_pop_clears_tail();
    issue_list_op(KIND_POP_FRONT, 32'h0, 4'd0);
    issue_list_op(KIND_GET, 32'h0, 4'd15);
    issue_list_op(KIND_GET, 32'h0, 4'd14);
  endtask

  // Random walk over the fill level: bursts lean toward filling, draining or neither,
  // so both the full and the empty list are visited often.
  task automatic test_random_walk(input int n_words);
    int   mode;
    int   burst_left;
    int   roll;
    int   push_pct;
    int   pop_pct;
    logic [POS_W-1:0] pos;
    burst_left = 0;
    mode       = 0;
    for (int k = 0; k < n_words; k++) begin
      if (burst_left == 0) begin
        mode       = $urandom_range(2);
        burst_left = $urandom_range(60, 10);
      end
      burst_left--;
      case (mode)
        0:       begin push_pct = 65; pop_pct = 15; end
        1:       begin push_pct = 15; pop_pct = 65; end
        default: begin push_pct = 32; pop_pct = 32; end
      endcase
      roll = $urandom_range(99);
      if ($urandom_range(3) == 0 && shadow_fill > 0)
        pos = POS_W'($urandom_range(shadow_fill - 1));
      else
        pos = POS_W'($urandom_range(DEPTH - 1));
      if (roll < push_pct)
        issue_list_op($urandom_range(1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT,
                      pick_handle(), pos);
      else if (roll < push_pct + pop_pct)
        issue_list_op(KIND_POP_FRONT, pick_handle(), pos);
      else
        issue_list_op(KIND_GET, pick_handle(), pos);
    end
  endtask

  // Same walk with neither side idling, so words move on every cycle.
  task automatic test_back_to_back(input int n_words);
    quiet = 1'b1;
    test_random_walk(n_words);
    quiet = 1'b0;
  endtask

  // Receiver stalls at random except during the quiet stretch.
  always @(negedge clk_i) begin
    out_stall_i <= (!quiet && $urandom_range(99) < 12);
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        if (mismatch_total < REPORT_MAX)
          $display("unexpected result: value=%h valid=%b count=%0d status=%0d",
                   value_o, valid_res_o, count_o, status_o);
        mismatch_total++;
      end else begin
        want = pending_results.pop_front();
        if (value_o !== want.value || valid_res_o !== want.hit ||
            count_o !== want.count || status_o !== want.status) begin
          if (mismatch_total < REPORT_MAX)
            $display({"mismatch: expected value=%h valid=%b count=%0d status=%0d,",
                      " got value=%h valid=%b count=%0d status=%0d"},
                     want.value, want.hit, want.count, want.status,
                     value_o, valid_res_o, count_o, status_o);
          mismatch_total++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < DEPTH; i++) shadow_slots[i] = '0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_list();
    test_fill_to_capacity();
    test_pop_clears_tail();
    test_random_walk(1000);
    test_back_to_back(426);
    in_valid_i <= 1'b0;

    // Let the last results come out before judging the run.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_total == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
